// ----- hw/rtl/h2rgb10_pkg.sv -----
// Package for the half-float RGB to RGB10A2 packer.
// Holds the binary16 field layout, unorm limits and packed word layout.
// No dependencies; every other file of the block refers to it by scoped names.
package h2rgb10_pkg;

    // binary16 layout
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned EXP_W     = 5;
    localparam int unsigned MANT_W    = 10;
    localparam int unsigned SIGN_BIT  = HALF_W - 1;
    localparam int unsigned EXP_LSB   = MANT_W;
    localparam int unsigned EXP_MSB   = EXP_LSB + EXP_W - 1;

    // exponent codes with a special meaning
    localparam logic [EXP_W-1:0] EXP_ZERO = 5'd0;
    localparam logic [EXP_W-1:0] EXP_ONE  = 5'd15;
    localparam logic [EXP_W-1:0] EXP_INF  = 5'd31;
    // value = (1024 + m) * 2^(e - SHIFT_BASE)
    localparam logic [EXP_W-1:0] SHIFT_BASE = 5'd25;

    // unorm10 output
    localparam int unsigned UNORM_W = 10;
    localparam logic [UNORM_W-1:0] UNORM_MAX  = 10'h3FF;
    localparam logic [UNORM_W-1:0] UNORM_ZERO = 10'h000;

    // packed word layout
    localparam int unsigned PACK_W  = 32;
    localparam int unsigned ALPHA_W = 2;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 2'b11;

    // product (1024+m)*1023 fits 21 bits; plus rounding term up to 2^23
    localparam int unsigned PROD_W = 21;
    localparam int unsigned SUM_W  = 25;

    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [UNORM_W-1:0] t_unorm;
    typedef logic [PACK_W-1:0]  t_pack;

endpackage

// ----- hw/rtl/h2rgb10_in_if.sv -----
// Input channel of the half-float packer: valid/ready plus three half channels.
// Depends on h2rgb10_pkg for the payload types.
interface h2rgb10_in_if;
    logic                  valid;
    logic                  ready;
    h2rgb10_pkg::t_half    red_half;
    h2rgb10_pkg::t_half    green_half;
    h2rgb10_pkg::t_half    blue_half;

    modport source (output valid, output red_half, output green_half, output blue_half,
                    input ready);
    modport sink   (input valid, input red_half, input green_half, input blue_half,
                    output ready);
endinterface

// ----- hw/rtl/h2rgb10_out_if.sv -----
// Output channel of the half-float packer: valid/ready plus the packed word.
// Depends on h2rgb10_pkg for the payload type.
interface h2rgb10_out_if;
    logic                  valid;
    logic                  ready;
    h2rgb10_pkg::t_pack    packed_pixel;

    modport source (output valid, output packed_pixel, input ready);
    modport sink   (input valid, input packed_pixel, output ready);
endinterface

// ----- hw/rtl/h2rgb10_unorm.sv -----
// Converts one binary16 channel to a 10-bit unorm code, clamped to [0,1].
// Pure combinational; depends on h2rgb10_pkg.
module h2rgb10_unorm (
    input  h2rgb10_pkg::t_half  i_half,
    output h2rgb10_pkg::t_unorm o_unorm
);

    logic [h2rgb10_pkg::EXP_W-1:0]  w_expo;
    logic [h2rgb10_pkg::MANT_W-1:0] w_mant;
    logic [h2rgb10_pkg::MANT_W:0]   w_sig;
    logic [h2rgb10_pkg::PROD_W-1:0] w_prod;
    logic [h2rgb10_pkg::EXP_W-1:0]  w_sh;
    logic [h2rgb10_pkg::SUM_W-1:0]  w_rnd;
    logic [h2rgb10_pkg::SUM_W-1:0]  w_sum;
    logic [h2rgb10_pkg::SUM_W-1:0]  w_scaled;

    assign w_expo = i_half[h2rgb10_pkg::EXP_MSB:h2rgb10_pkg::EXP_LSB];
    assign w_mant = i_half[h2rgb10_pkg::MANT_W-1:0];
    assign w_sig  = {1'b1, w_mant};

    // scale by 1023 as (x << 10) - x
    assign w_prod = {w_sig, 10'b0} - {10'b0, w_sig};

    // add one half LSB of the target, then shift down
    assign w_sh     = h2rgb10_pkg::SHIFT_BASE - w_expo;
    assign w_rnd    = h2rgb10_pkg::SUM_W'(1) << (w_sh - 5'd1);
    assign w_sum    = {4'b0, w_prod} + w_rnd;
    assign w_scaled = w_sum >> w_sh;

    // pick the special cases first: negative, zero/subnormal, inf/NaN, >= 1
    always_comb begin
        if (i_half[h2rgb10_pkg::SIGN_BIT]) begin
            o_unorm = h2rgb10_pkg::UNORM_ZERO;
        end else if (w_expo == h2rgb10_pkg::EXP_ZERO) begin
            o_unorm = h2rgb10_pkg::UNORM_ZERO;
        end else if (w_expo == h2rgb10_pkg::EXP_INF) begin
            o_unorm = (w_mant == '0) ? h2rgb10_pkg::UNORM_MAX : h2rgb10_pkg::UNORM_ZERO;
        end else if (w_expo >= h2rgb10_pkg::EXP_ONE) begin
            o_unorm = h2rgb10_pkg::UNORM_MAX;
        end else begin
            o_unorm = w_scaled[h2rgb10_pkg::UNORM_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/half_rgb_to_rgb10a2_pack.sv -----
// Packs three binary16 colour channels into one R10G10B10A2 unorm word
// (R in 9:0, G in 19:10, B in 29:20, alpha fixed at 3). Each channel is
// clamped to [0,1] and scaled as v*1023 rounded half up; negatives, zero,
// subnormals and NaN give 0, one and above and +infinity give 1023. The
// block takes one pixel per clock; each pixel passes through one input
// register, the three converters and one output register.
// Both registers advance together, so throughput stays at one word a cycle
// as long as the output side takes words; a stall on the output lets an empty
// input register fill and then holds both.
// Depends on h2rgb10_pkg, h2rgb10_in_if, h2rgb10_out_if and h2rgb10_unorm.
module half_rgb_to_rgb10a2_pack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    h2rgb10_in_if.sink    i_pix,
    h2rgb10_out_if.source o_pix
);

    logic                r_s1_valid;
    h2rgb10_pkg::t_half  r_s1_red;
    h2rgb10_pkg::t_half  r_s1_green;
    h2rgb10_pkg::t_half  r_s1_blue;
    logic                r_out_valid;
    h2rgb10_pkg::t_pack  r_out_word;

    logic                w_s2_load;
    logic                w_s1_load;
    h2rgb10_pkg::t_unorm w_red;
    h2rgb10_pkg::t_unorm w_green;
    h2rgb10_pkg::t_unorm w_blue;
    h2rgb10_pkg::t_pack  n_out_word;

    // advance when the next stage is empty or draining this cycle
    assign w_s2_load   = !r_out_valid || o_pix.ready;
    assign w_s1_load   = !r_s1_valid || w_s2_load;
    assign i_pix.ready = w_s1_load;

    // hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_pix.valid) begin
            r_s1_red   <= i_pix.red_half;
            r_s1_green <= i_pix.green_half;
            r_s1_blue  <= i_pix.blue_half;
        end
    end

    // convert each channel
    h2rgb10_unorm u_red   (.i_half(r_s1_red),   .o_unorm(w_red));
    h2rgb10_unorm u_green (.i_half(r_s1_green), .o_unorm(w_green));
    h2rgb10_unorm u_blue  (.i_half(r_s1_blue),  .o_unorm(w_blue));

    assign n_out_word = {h2rgb10_pkg::ALPHA_OPAQUE, w_blue, w_green, w_red};

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load && r_s1_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.packed_pixel = r_out_word;

`ifndef SYNTHESIS
    // an accepted word lands in the input register
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_s1_valid)
        else $error("accepted word missing from input register");

    // a blocked input register keeps its word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_load) |=>
            (r_s1_valid && $stable(r_s1_red) && $stable(r_s1_green) && $stable(r_s1_blue)))
        else $error("input register lost a word under stall");

    // positive infinity or one on red saturates
    a_red_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_load && r_s1_valid && (r_s1_red == 16'h7C00 || r_s1_red == 16'h3C00)) |=>
            (o_pix.packed_pixel[h2rgb10_pkg::UNORM_W-1:0] == h2rgb10_pkg::UNORM_MAX))
        else $error("red channel did not saturate");

    // negative red gives zero
    a_red_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_load && r_s1_valid && r_s1_red[h2rgb10_pkg::SIGN_BIT]) |=>
            (o_pix.packed_pixel[h2rgb10_pkg::UNORM_W-1:0] == h2rgb10_pkg::UNORM_ZERO))
        else $error("negative red channel not cleared");
`endif

endmodule
